@@ sv/jpp_pkg.sv @@
// ----------------------------------------------------------------------------
// jpp_pkg
// Shared types, constants and helpers of the JSON pretty printer.
// ----------------------------------------------------------------------------
package jpp_pkg;

  // nesting limit and derived widths
  localparam int MAX_DEPTH    = 255;
  localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
  localparam int IW_W         = 5;
  localparam int INDENT_W     = 12;
  localparam int PROD_W       = DEPTH_W + IW_W;
  localparam int INDENT_MAX   = 4095;
  localparam int MAX_RESULTS  = 3;
  localparam int CNT_W        = 2;

  localparam logic [IW_W-1:0] INDENT_RESET = 5'd2;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_BREAK = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [7:0]          out_byte;
    logic [INDENT_W-1:0] indent_count;
    logic                last;
  } result_t;

  typedef logic [DEPTH_W-1:0] depth_t;

  // literal byte item
  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r.kind         = KIND_BYTE;
    r.out_byte     = b;
    r.indent_count = '0;
    r.last         = 1'b0;
    return r;
  endfunction

  // newline plus indent item, count saturated
  function automatic result_t mk_break(input depth_t d, input logic [IW_W-1:0] w);
    result_t           r;
    logic [PROD_W-1:0] prod;
    prod           = PROD_W'(d) * PROD_W'(w);
    r.kind         = KIND_BREAK;
    r.out_byte     = CH_LF;
    r.indent_count = (32'(prod) > INDENT_MAX) ? INDENT_W'(INDENT_MAX) : INDENT_W'(prod);
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic depth_t depth_up(input depth_t d);
    return (32'(d) < MAX_DEPTH) ? d + depth_t'(1) : d;
  endfunction

  function automatic depth_t depth_down(input depth_t d);
    return (d != '0) ? d - depth_t'(1) : d;
  endfunction

endpackage

@@ sv/jpp_in_if.sv @@
// ----------------------------------------------------------------------------
// jpp_in_if
// Source text channel: one byte of JSON text per item.
// ----------------------------------------------------------------------------
interface jpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

@@ sv/jpp_out_if.sv @@
// ----------------------------------------------------------------------------
// jpp_out_if
// Formatted output channel: one literal byte or one line break per item.
// ----------------------------------------------------------------------------
interface jpp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [11:0] indent_count;
  logic        last;

  modport source (output valid, kind, out_byte, indent_count, last, input ready);
  modport sink   (input valid, kind, out_byte, indent_count, last, output ready);
endinterface

@@ sv/jpp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// jpp_cfg_if
// Configuration write channel for the indent width register.
// ----------------------------------------------------------------------------
interface jpp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/jpp_step.sv @@
// ----------------------------------------------------------------------------
// jpp_step
// Parser state and the expansion of one source byte into up to three results.
// ----------------------------------------------------------------------------
module jpp_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_text,
  input  logic [jpp_pkg::IW_W-1:0]      indent_width,
  output jpp_pkg::result_t              res [jpp_pkg::MAX_RESULTS],
  output logic [jpp_pkg::CNT_W-1:0]     res_count
);
  import jpp_pkg::*;

  logic   in_string, escape_next, open_pending, pending_is_brace;
  depth_t nest_depth;
  logic   in_string_next, escape_next_next, open_pending_next, pending_is_brace_next;
  depth_t nest_depth_next;

  // state registers, advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_string        <= 1'b0;
      escape_next      <= 1'b0;
      nest_depth       <= '0;
      open_pending     <= 1'b0;
      pending_is_brace <= 1'b0;
    end else if (accept) begin
      in_string        <= in_string_next;
      escape_next      <= escape_next_next;
      nest_depth       <= nest_depth_next;
      open_pending     <= open_pending_next;
      pending_is_brace <= pending_is_brace_next;
    end
  end

  // expansion of the byte into results and next state
  always_comb begin
    logic             handled;
    logic [7:0]       match;
    logic [CNT_W-1:0] n;
    handled               = 1'b0;
    n                     = '0;
    match                 = pending_is_brace ? CH_RBRACE : CH_RBRACK;
    in_string_next        = in_string;
    escape_next_next      = escape_next;
    nest_depth_next       = nest_depth;
    open_pending_next     = open_pending;
    pending_is_brace_next = pending_is_brace;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = mk_byte(8'h00);

    if (in_string) begin
      res[n] = mk_byte(in_byte);
      n      = n + CNT_W'(1);
      if (escape_next) escape_next_next = 1'b0;
      else if (in_byte == CH_BSLASH) escape_next_next = 1'b1;
      else if (in_byte == CH_QUOTE) in_string_next = 1'b0;
    end else if (!(in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
      // resolve a held open bracket
      if (open_pending) begin
        open_pending_next = 1'b0;
        if (in_byte == match) begin
          res[n]  = mk_byte(in_byte);
          n       = n + CNT_W'(1);
          handled = 1'b1;
        end else begin
          nest_depth_next = depth_up(nest_depth_next);
          res[n]          = mk_break(nest_depth_next, indent_width);
          n               = n + CNT_W'(1);
        end
      end
      if (!handled) begin
        if (in_byte == CH_QUOTE) begin
          in_string_next   = 1'b1;
          escape_next_next = 1'b0;
          res[n]           = mk_byte(in_byte);
          n                = n + CNT_W'(1);
        end else if (in_byte inside {CH_LBRACE, CH_LBRACK}) begin
          res[n]                = mk_byte(in_byte);
          n                     = n + CNT_W'(1);
          open_pending_next     = 1'b1;
          pending_is_brace_next = (in_byte == CH_LBRACE);
        end else if (in_byte inside {CH_RBRACE, CH_RBRACK}) begin
          nest_depth_next = depth_down(nest_depth_next);
          res[n]          = mk_break(nest_depth_next, indent_width);
          n               = n + CNT_W'(1);
          res[n]          = mk_byte(in_byte);
          n               = n + CNT_W'(1);
        end else if (in_byte == CH_COMMA) begin
          res[n] = mk_byte(in_byte);
          n      = n + CNT_W'(1);
          res[n] = mk_break(nest_depth_next, indent_width);
          n      = n + CNT_W'(1);
        end else if (in_byte == CH_COLON) begin
          res[n] = mk_byte(in_byte);
          n      = n + CNT_W'(1);
          res[n] = mk_byte(CH_SPACE);
          n      = n + CNT_W'(1);
        end else begin
          res[n] = mk_byte(in_byte);
          n      = n + CNT_W'(1);
        end
      end
    end

    // end of document: flush a held open, then back to reset state
    if (end_of_text) begin
      if (open_pending_next) begin
        nest_depth_next = depth_up(nest_depth_next);
        res[n]          = mk_break(nest_depth_next, indent_width);
        n               = n + CNT_W'(1);
      end
      in_string_next        = 1'b0;
      escape_next_next      = 1'b0;
      nest_depth_next       = '0;
      open_pending_next     = 1'b0;
      pending_is_brace_next = 1'b0;
    end

    if (n != '0) res[n - CNT_W'(1)].last = 1'b1;
    res_count = n;
  end

endmodule

@@ sv/jpp_outbuf.sv @@
// ----------------------------------------------------------------------------
// jpp_outbuf
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module jpp_outbuf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  jpp_pkg::result_t          load_res [jpp_pkg::MAX_RESULTS],
  input  logic [jpp_pkg::CNT_W-1:0] load_count,
  output logic                      free,
  jpp_out_if.source                 out_ch
);
  import jpp_pkg::*;

  result_t          items [MAX_RESULTS];
  logic [CNT_W-1:0] rem;
  logic             fire;

  assign fire = out_ch.valid && out_ch.ready;
  // room for a new item once the last held result leaves
  assign free = (rem == '0) || ((rem == CNT_W'(1)) && out_ch.ready);

  // held result count
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= load_count;
    end else if (fire) begin
      rem <= rem - CNT_W'(1);
    end
  end

  // result payload, shifts toward the head as items leave
  always_ff @(posedge clk) begin
    if (load) begin
      items <= load_res;
    end else if (fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) items[i] <= items[i + 1];
    end
  end

  // output channel
  assign out_ch.valid        = (rem != '0);
  assign out_ch.kind         = items[0].kind;
  assign out_ch.out_byte     = items[0].out_byte;
  assign out_ch.indent_count = items[0].indent_count;
  assign out_ch.last         = items[0].last;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free) else $error("result buffer loaded while holding results");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> rem == $past(load_count)) else $error("held count differs from load");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (fire && !load) |=> rem == $past(rem) - CNT_W'(1)) else $error("drain count slip");
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.last == (rem == CNT_W'(1))))
    else $error("last flag not on final held result");
`endif

endmodule

@@ sv/json_pretty_printer_unit.sv @@
// ----------------------------------------------------------------------------
// json_pretty_printer_unit
// Streaming JSON pretty printer: one source byte in, zero to three items out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  in_ch    in   in_byte[7:0], end_of_text                 valid/ready
//  out_ch   out  kind, out_byte[7:0], indent_count[11:0],  valid/ready
//               last
//  cfg      in   data[4:0] (indent_width)                  valid/ready, ready=1
//
//  An accepted byte is expanded in the same cycle and its results sit in the
//  result register from the next cycle on, one leaving per cycle while out_ch
//  is ready. A byte with one result or none lets the next byte in every cycle;
//  a byte with more results holds input while the result register drains,
//  until its last result leaves. Stalls on out_ch hold input the same way.
//  Synchronous reset clears parse state and sets indent width to 2.
// ----------------------------------------------------------------------------
module json_pretty_printer_unit (
  input  logic       clk,
  input  logic       rst,
  jpp_in_if.sink     in_ch,
  jpp_out_if.source  out_ch,
  jpp_cfg_if.sink    cfg
);
  import jpp_pkg::*;

  logic [IW_W-1:0]  indent_width;
  logic             accept;
  logic             free;
  result_t          res [MAX_RESULTS];
  logic [CNT_W-1:0] res_count;

  // indent width register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      indent_width <= INDENT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      indent_width <= cfg.data;
    end
  end

  // input handshake
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  jpp_step u_step (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_ch.in_byte),
    .end_of_text  (in_ch.end_of_text),
    .indent_width (indent_width),
    .res          (res),
    .res_count    (res_count)
  );

  jpp_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && (res_count != '0)),
    .load_res   (res),
    .load_count (res_count),
    .free       (free),
    .out_ch     (out_ch)
  );

endmodule

@@ test/json_pretty_printer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_pretty_printer_unit_tb
// Streams JSON text through the pretty printer and checks every output item
// against a cycle-free layout predictor: directed corner cases, indent width
// settings, deep nesting, then random documents, broken text and noise.
// ----------------------------------------------------------------------------
module json_pretty_printer_unit_tb;
  import jpp_pkg::*;

  logic clk;
  logic rst;

  jpp_in_if  in_ch ();
  jpp_out_if out_ch ();
  jpp_cfg_if cfg_ch ();

  json_pretty_printer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // layout predictor state
  logic [IW_W-1:0] indent_w;
  logic            str_open;
  logic            esc_pending;
  depth_t          nest;
  logic            held_open;
  logic            held_brace;

  result_t    layout_q[$];   // output items still to arrive, oldest first
  logic [7:0] text_q[$];     // source text of the document being built
  int         fail_count;
  int         sent_bytes;    // source bytes accepted so far
  logic       idle_en;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // literal byte item
  function automatic result_t plain_item(input logic [7:0] b);
    result_t r;
    r.kind         = KIND_BYTE;
    r.out_byte     = b;
    r.indent_count = '0;
    r.last         = 1'b0;
    return r;
  endfunction

  // newline item at the current nesting level
  function automatic result_t newline_item();
    result_t r;
    int      spaces;
    spaces = int'(nest) * int'(indent_w);
    if (spaces > INDENT_MAX) spaces = INDENT_MAX;
    r.kind         = KIND_BREAK;
    r.out_byte     = CH_LF;
    r.indent_count = INDENT_W'(spaces);
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic void clear_parse();
    str_open    = 1'b0;
    esc_pending = 1'b0;
    nest        = '0;
    held_open   = 1'b0;
    held_brace  = 1'b0;
  endfunction

  // layout of one accepted source byte
  function automatic void format_byte(input logic [7:0] c, input logic eot);
    result_t    outs[$];
    logic [7:0] close_ch;
    logic       done;
    done = 1'b0;
    if (str_open) begin
      outs.insert(outs.size(), plain_item(c));
      if (esc_pending) esc_pending = 1'b0;
      else if (c == CH_BSLASH) esc_pending = 1'b1;
      else if (c == CH_QUOTE) str_open = 1'b0;
    end else if (!(c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
      // a held open resolves on the next significant byte
      if (held_open) begin
        close_ch  = held_brace ? CH_RBRACE : CH_RBRACK;
        held_open = 1'b0;
        if (c == close_ch) begin
          outs.insert(outs.size(), plain_item(c));
          done = 1'b1;
        end else begin
          if (32'(nest) < MAX_DEPTH) nest = nest + depth_t'(1);
          outs.insert(outs.size(), newline_item());
        end
      end
      if (!done) begin
        case (c)
          CH_QUOTE: begin
            str_open    = 1'b1;
            esc_pending = 1'b0;
            outs.insert(outs.size(), plain_item(c));
          end
          CH_LBRACE, CH_LBRACK: begin
            outs.insert(outs.size(), plain_item(c));
            held_open  = 1'b1;
            held_brace = (c == CH_LBRACE);
          end
          CH_RBRACE, CH_RBRACK: begin
            if (nest != '0) nest = nest - depth_t'(1);
            outs.insert(outs.size(), newline_item());
            outs.insert(outs.size(), plain_item(c));
          end
          CH_COMMA: begin
            outs.insert(outs.size(), plain_item(c));
            outs.insert(outs.size(), newline_item());
          end
          CH_COLON: begin
            outs.insert(outs.size(), plain_item(c));
            outs.insert(outs.size(), plain_item(CH_SPACE));
          end
          default: outs.insert(outs.size(), plain_item(c));
        endcase
      end
    end
    // end of text flushes a held open and starts a fresh document
    if (eot) begin
      if (held_open) begin
        if (32'(nest) < MAX_DEPTH) nest = nest + depth_t'(1);
        outs.insert(outs.size(), newline_item());
      end
      clear_parse();
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) layout_q.insert(layout_q.size(), outs[i]);
  endfunction

  // send one source byte, with an occasional gap first
  task automatic send_byte(input logic [7:0] b, input logic eot);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
    format_byte(b, eot);
  endtask

  // send the built text, end of text on its last byte
  task automatic stream_doc();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // quiesce, then write the indent width register
  task automatic write_indent(input logic [IW_W-1:0] w);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (layout_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = w;
    do @(posedge clk); while (!cfg_ch.ready);
    indent_w = w;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // append one byte to the text
  function automatic void add_char(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // optional whitespace run
  function automatic void gen_ws();
    logic [7:0] ws [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) add_char(ws[$urandom_range(0, 3)]);
  endfunction

  // string with random content and escapes
  function automatic void gen_string();
    logic [7:0] b;
    add_char(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 5) == 0) begin
        add_char(CH_BSLASH);
        add_char(8'($urandom_range(0, 255)));
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h61;
        add_char(b);
      end
    end
    add_char(CH_QUOTE);
  endfunction

  function automatic void gen_scalar();
    string lits [5] = '{"true", "false", "null", "-12.5e3", "7"};
    put_str(lits[$urandom_range(0, 4)]);
  endfunction

  // well-formed value, nesting bounded
  function automatic void gen_value(input int lvl);
    int pick;
    int cnt;
    pick = (lvl >= 3) ? $urandom_range(2, 3) : $urandom_range(0, 3);
    cnt  = $urandom_range(0, 3);
    case (pick)
      0: begin
        add_char(CH_LBRACE);
        gen_ws();
        for (int i = 0; i < cnt; i++) begin
          if (i > 0) begin
            add_char(CH_COMMA);
            gen_ws();
          end
          gen_string();
          gen_ws();
          add_char(CH_COLON);
          gen_ws();
          gen_value(lvl + 1);
          gen_ws();
        end
        add_char(CH_RBRACE);
      end
      1: begin
        add_char(CH_LBRACK);
        gen_ws();
        for (int i = 0; i < cnt; i++) begin
          if (i > 0) begin
            add_char(CH_COMMA);
            gen_ws();
          end
          gen_value(lvl + 1);
          gen_ws();
        end
        add_char(CH_RBRACK);
      end
      2: gen_string();
      default: gen_scalar();
    endcase
  endfunction

  function automatic void build_doc();
    text_q.delete();
    gen_ws();
    gen_value(0);
    gen_ws();
  endfunction

  // corner cases at the reset indent width
  task automatic test_directed();
    // empty pair with whitespace inside
    text_q.delete();
    put_str("{ }");
    stream_doc();
    // held open ended by whitespace at end of text
    text_q.delete();
    put_str("[ ");
    stream_doc();
    // mismatched close after a held open
    text_q.delete();
    put_str("{]");
    stream_doc();
    // close at depth zero, after dropped tab and newline
    text_q.delete();
    add_char(CH_TAB);
    add_char(CH_LF);
    add_char(CH_RBRACK);
    stream_doc();
    // escapes, cr inside a string, punctuation, extreme bytes, open at end
    text_q.delete();
    put_str("\"\\\"");
    add_char(CH_CR);
    put_str("\\\\\",:");
    add_char(8'hFF);
    add_char(8'h00);
    add_char(CH_LBRACE);
    stream_doc();
  endtask

  // indent width settings, extremes first
  task automatic test_indent_widths();
    logic [IW_W-1:0] widths [4];
    widths = '{5'd0, 5'd31, 5'd1, 5'($urandom_range(0, 16))};
    foreach (widths[i]) begin
      write_indent(widths[i]);
      build_doc();
      stream_doc();
    end
  endtask

  // indent saturation at the widest setting
  task automatic test_deep_nesting();
    write_indent(5'd31);
    text_q.delete();
    repeat (134) add_char(CH_LBRACK);
    put_str("1]]");
    stream_doc();
  endtask

  // random documents, broken text and noise, until the byte total is reached
  task automatic test_random_text(input int target);
    int ndoc;
    int idx;
    int mode;
    ndoc = 0;
    do begin
      if (ndoc % 6 == 5) write_indent(5'($urandom_range(0, 31)));
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        build_doc();
      end else if (mode < 17) begin
        // broken: cut short, swapped or inserted close bracket, or stray byte
        build_doc();
        idx = $urandom_range(0, text_q.size() - 1);
        case (mode)
          14: while (text_q.size() > idx + 1) void'(text_q.pop_back());
          15: begin
            if (text_q[idx] == CH_RBRACE) text_q[idx] = CH_RBRACK;
            else if (text_q[idx] == CH_RBRACK) text_q[idx] = CH_RBRACE;
            else text_q.insert(idx, CH_RBRACE);
          end
          default: text_q.insert(idx, 8'($urandom_range(0, 255)));
        endcase
      end else begin
        text_q.delete();
        repeat ($urandom_range(5, 20)) add_char(8'($urandom_range(0, 255)));
      end
      stream_doc();
      ndoc++;
    end while (sent_bytes < target);
  endtask

  // output ready with random stall bursts
  initial begin : out_stall
    int hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        hold         = $urandom_range(1, 14) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // compare each output item with the oldest predicted one
  always @(posedge clk) begin : out_check
    result_t got;
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind         = out_ch.kind;
      got.out_byte     = out_ch.out_byte;
      got.indent_count = out_ch.indent_count;
      got.last         = out_ch.last;
      if (layout_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, %s", $time,
                 $sformatf("actual kind=%0d byte=%02h indent=%0d last=%0d",
                           got.kind, got.out_byte, got.indent_count, got.last));
        fail_count++;
      end else begin
        want = layout_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected kind=%0d byte=%02h indent=%0d last=%0d, %s",
                   $time, want.kind, want.out_byte, want.indent_count, want.last,
                   $sformatf("actual kind=%0d byte=%02h indent=%0d last=%0d",
                             got.kind, got.out_byte, got.indent_count, got.last));
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.end_of_text = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    fail_count        = 0;
    sent_bytes        = 0;
    idle_en           = 1'b1;
    indent_w          = INDENT_RESET;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_indent_widths();
    test_deep_nesting();
    test_random_text(200);
    // last stretch runs with no idling
    idle_en = 1'b0;
    test_random_text(240);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (layout_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/jpp_pkg.sv
sv/jpp_in_if.sv
sv/jpp_out_if.sv
sv/jpp_cfg_if.sv
sv/jpp_step.sv
sv/jpp_outbuf.sv
sv/json_pretty_printer_unit.sv
test/json_pretty_printer_unit_tb.sv
